FILE: sv/dpp_pkg.sv
// dpp_pkg: shared types for the decimal period unit.
// State encoding and controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package dpp_pkg;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD5,
		S_STEP,
		S_DONE
	} state_t;

	// Multiples of p kept for the times-ten reduction: 1*p .. MULT_MAX*p
	localparam int MULT_MAX = 9;

	typedef struct packed {
		logic load;
		logic step;
		logic out_zero;
	} cmd_t;

	typedef struct packed {
		logic div5;
		logic trivial;
		logic hit;
		logic at_half;
	} sts_t;

endpackage

FILE: sv/decimal_period_of_prime_unit.sv
// decimal_period_of_prime_unit: top level, decimal period length of 1/p.
// Instantiates dpp_ctrl and dpp_datapath; uses dpp_pkg.
//
// channel   | ports                  | transaction
// ----------+------------------------+----------------------------------
// input     | start, busy, prime     | start && !busy at a rising edge
// result    | done, period,          | done high for one cycle
//           | full_reptend           |
//
// Steps per transaction: the period found, or (p-1)/2 when none is found,
// and 0 for p that is even, below 2 or a multiple of 5. S_IDLE accepts,
// S_MOD5 checks p mod 5 and the trivial cases, each step in S_STEP is one
// 10*r mod p reduction, and S_DONE holds done.
// Reset is asynchronous, active low, and returns the unit to idle.
// The receiver cannot stall; busy is low again the cycle after done.
`timescale 1ns / 1ps

module decimal_period_of_prime_unit #(
	parameter int PRIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [PRIME_BITS-1:0] prime,
	output logic                  done,
	output logic [PRIME_BITS-1:0] period,
	output logic                  full_reptend
);

	dpp_pkg::cmd_t cmd;
	dpp_pkg::sts_t sts;

	dpp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	dpp_datapath #(
		.PRIME_BITS (PRIME_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.prime        (prime),
		.cmd          (cmd),
		.sts          (sts),
		.period       (period),
		.full_reptend (full_reptend)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy)
		else $error("result strobe longer than one cycle");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	a_full_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && full_reptend |-> period != '0)
		else $error("full reptend with zero period");

endmodule

FILE: sv/dpp_datapath.sv
// dpp_datapath: operand, multiples of p, remainder, step counter and result registers.
// Checks p mod 5 by a nibble sum and runs one r = 10*r mod p step per cycle.
// Depends on dpp_pkg.
`timescale 1ns / 1ps

module dpp_datapath #(
	parameter int PRIME_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PRIME_BITS-1:0] prime,
	input  dpp_pkg::cmd_t         cmd,
	output dpp_pkg::sts_t         sts,
	output logic [PRIME_BITS-1:0] period,
	output logic                  full_reptend
);

	localparam int N  = PRIME_BITS;
	localparam int W  = PRIME_BITS + 4;
	localparam int NN = (PRIME_BITS + 3) / 4;

	logic [N-1:0]  p_q;
	logic [N-1:0]  r_q;
	logic [N-1:0]  k_q;
	logic [N-1:0]  half_q;
	logic [N-1:0]  period_q;
	logic          full_q;
	logic [W-1:0]  mult_q [1:dpp_pkg::MULT_MAX];

	logic [W-1:0]    mult_d [1:dpp_pkg::MULT_MAX];
	logic [W-1:0]    pw;
	logic [4*NN-1:0] p_pad;
	logic [7:0]      nsum;
	logic [4:0]      fold;
	logic [W-1:0]    t10;
	logic [W-1:0]    sub;
	logic [W-1:0]    diff;
	logic [N-1:0]    r_next;

	// multiples of the incoming prime, built from shifts and at most one add or subtract
	always_comb begin
		pw = {4'b0, prime};
		mult_d[1] = pw;
		mult_d[2] = pw << 1;
		mult_d[3] = (pw << 1) + pw;
		mult_d[4] = pw << 2;
		mult_d[5] = (pw << 2) + pw;
		mult_d[6] = ((pw << 1) + pw) << 1;
		mult_d[7] = (pw << 3) - pw;
		mult_d[8] = pw << 3;
		mult_d[9] = (pw << 3) + pw;
	end

	// p mod 5: 16 = 1 mod 5, so summing hex digits keeps the residue
	always_comb begin
		p_pad = '0;
		p_pad[N-1:0] = p_q;
		nsum = '0;
		for (int i = 0; i < NN; i++) begin
			nsum = nsum + {4'b0, p_pad[4*i +: 4]};
		end
		fold = {1'b0, nsum[7:4]} + {1'b0, nsum[3:0]};
		if (fold >= 5'd20) begin
			fold = fold - 5'd20;
		end
		if (fold >= 5'd10) begin
			fold = fold - 5'd10;
		end
		if (fold >= 5'd5) begin
			fold = fold - 5'd5;
		end
	end

	// 10*r mod p: 10*r < 10p, remove the largest multiple not above it
	always_comb begin
		t10 = ({4'b0, r_q} << 3) + ({4'b0, r_q} << 1);
		sub = '0;
		for (int i = 1; i <= dpp_pkg::MULT_MAX; i++) begin
			if (t10 >= mult_q[i]) begin
				sub = mult_q[i];
			end
		end
		diff   = t10 - sub;
		r_next = diff[N-1:0];
	end

	always_comb begin
		sts.div5    = (fold == 5'd0);
		sts.trivial = (p_q[N-1:1] == '0) || !p_q[0];
		sts.hit     = (r_next == {{(N-1){1'b0}}, 1'b1});
		sts.at_half = (k_q == half_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q      <= '0;
			r_q      <= '0;
			k_q      <= '0;
			half_q   <= '0;
			period_q <= '0;
			full_q   <= 1'b0;
			for (int i = 1; i <= dpp_pkg::MULT_MAX; i++) begin
				mult_q[i] <= '0;
			end
		end else begin
			if (cmd.load) begin
				p_q    <= prime;
				half_q <= (prime - 1'b1) >> 1;
				r_q    <= {{(N-1){1'b0}}, 1'b1};
				k_q    <= {{(N-1){1'b0}}, 1'b1};
				for (int i = 1; i <= dpp_pkg::MULT_MAX; i++) begin
					mult_q[i] <= mult_d[i];
				end
			end
			if (cmd.step) begin
				if (sts.hit) begin
					period_q <= k_q;
					full_q   <= 1'b0;
				end else if (sts.at_half) begin
					period_q <= p_q - 1'b1;
					full_q   <= 1'b1;
				end else begin
					r_q <= r_next;
					k_q <= k_q + 1'b1;
				end
			end
			if (cmd.out_zero) begin
				period_q <= '0;
				full_q   <= 1'b0;
			end
		end
	end

	assign period       = period_q;
	assign full_reptend = full_q;

endmodule

FILE: sv/dpp_ctrl.sv
// dpp_ctrl: controller state machine for the decimal period unit.
// Sequences load, mod-5 check, remainder stepping and result strobe.
// Depends on dpp_pkg.
`timescale 1ns / 1ps

module dpp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  dpp_pkg::sts_t sts,
	output dpp_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	dpp_pkg::state_t state_q;
	dpp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dpp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dpp_pkg::S_IDLE: begin
				if (start) begin
					state_d = dpp_pkg::S_MOD5;
				end
			end
			dpp_pkg::S_MOD5: begin
				state_d = (sts.trivial || sts.div5) ? dpp_pkg::S_DONE
					: dpp_pkg::S_STEP;
			end
			dpp_pkg::S_STEP: begin
				if (sts.hit || sts.at_half) begin
					state_d = dpp_pkg::S_DONE;
				end
			end
			dpp_pkg::S_DONE: begin
				state_d = dpp_pkg::S_IDLE;
			end
			default: state_d = dpp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			dpp_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			dpp_pkg::S_MOD5: begin
				cmd.out_zero = sts.trivial || sts.div5;
			end
			dpp_pkg::S_STEP: begin
				cmd.step = 1'b1;
			end
			dpp_pkg::S_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
